// File: hdl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and helpers of the go-back-N link endpoint.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int TABLE_SIZE  = 8;
    localparam int MAX_PAYLOAD = 64;
    localparam int REF_WIDTH   = 16;
    localparam int MAX_CREDIT  = 8;

    localparam int SEQ_W    = $clog2(TABLE_SIZE);
    localparam int LEN_W    = 7;
    localparam int CREDIT_W = 4;
    localparam int KIND_W   = 3;
    localparam int CODE_W   = 3;
    localparam int FTYPE_W  = 2;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // input operation
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_QUEUE = 1'b1;

    // received frame types
    localparam logic [FTYPE_W-1:0] FT_DATA = 2'd0;
    localparam logic [FTYPE_W-1:0] FT_ACK  = 2'd1;
    localparam logic [FTYPE_W-1:0] FT_NACK = 2'd2;

    // classified commands
    localparam logic [CODE_W-1:0] CMD_NOP   = 3'd0;
    localparam logic [CODE_W-1:0] CMD_DATA  = 3'd1;
    localparam logic [CODE_W-1:0] CMD_ACK   = 3'd2;
    localparam logic [CODE_W-1:0] CMD_NACK  = 3'd3;
    localparam logic [CODE_W-1:0] CMD_QUEUE = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DATA    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NACK    = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [SEQ_W-1:0]     send_seq;
        logic [SEQ_W-1:0]     ack_seq;
        logic [REF_WIDTH-1:0] buf_ref;
        logic [LEN_W-1:0]     length;
        logic [CREDIT_W-1:0]  credit;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SEQ_W-1:0]     send_seq;
        logic [SEQ_W-1:0]     ack_seq;
        logic [REF_WIDTH-1:0] buf_ref;
        logic [LEN_W-1:0]     length;
        logic                 accepted;
        logic                 last;
    } res_t;

    function automatic logic [SEQ_W-1:0] ring_next(input logic [SEQ_W-1:0] v);
        logic [SEQ_W-1:0] r;
        if (v == SEQ_W'(TABLE_SIZE - 1))
        begin
            r = '0;
        end
        else
        begin
            r = v + SEQ_W'(1);
        end
        return r;
    endfunction

endpackage

// File: hdl/gbn_front.sv
// ----------------------------------------------------------------------------
// gbn_front
// Classifies an input request into a command and clamps length and credit.
// ----------------------------------------------------------------------------
module gbn_front (
    input  logic                          operation,
    input  logic [gbn_pkg::FTYPE_W-1:0]   frame_type,
    input  logic [gbn_pkg::SEQ_W-1:0]     frame_send_seq,
    input  logic [gbn_pkg::SEQ_W-1:0]     frame_ack_seq,
    input  logic [gbn_pkg::REF_WIDTH-1:0] payload_ref,
    input  logic [gbn_pkg::LEN_W-1:0]     payload_length,
    input  logic [gbn_pkg::CREDIT_W-1:0]  tx_credit,
    output gbn_pkg::cmd_t                 cmd
);

    always_comb
    begin
        cmd.send_seq = frame_send_seq;
        cmd.ack_seq  = frame_ack_seq;
        cmd.buf_ref  = payload_ref;
        if (payload_length > gbn_pkg::LEN_W'(gbn_pkg::MAX_PAYLOAD))
        begin
            cmd.length = gbn_pkg::LEN_W'(gbn_pkg::MAX_PAYLOAD);
        end
        else
        begin
            cmd.length = payload_length;
        end
        if (tx_credit > gbn_pkg::CREDIT_W'(gbn_pkg::MAX_CREDIT))
        begin
            cmd.credit = gbn_pkg::CREDIT_W'(gbn_pkg::MAX_CREDIT);
        end
        else
        begin
            cmd.credit = tx_credit;
        end
        if (operation == gbn_pkg::OP_QUEUE)
        begin
            cmd.code = gbn_pkg::CMD_QUEUE;
        end
        else
        begin
            case (frame_type)
                gbn_pkg::FT_DATA: cmd.code = gbn_pkg::CMD_DATA;
                gbn_pkg::FT_ACK:  cmd.code = gbn_pkg::CMD_ACK;
                gbn_pkg::FT_NACK: cmd.code = gbn_pkg::CMD_NACK;
                default:          cmd.code = gbn_pkg::CMD_NOP;
            endcase
        end
    end

endmodule

// File: hdl/gbn_queue.sv
// ----------------------------------------------------------------------------
// gbn_queue
// Two-entry command queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module gbn_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbn_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output gbn_pkg::cmd_t head
);

    gbn_pkg::cmd_t slot_reg [gbn_pkg::Q_DEPTH];
    logic [gbn_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [gbn_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [gbn_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [gbn_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [gbn_pkg::QCNT_W-1:0] count_reg;
    logic [gbn_pkg::QCNT_W-1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == gbn_pkg::QCNT_W'(gbn_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == gbn_pkg::QPTR_W'(gbn_pkg::Q_DEPTH - 1)) ? '0
                        : wr_ptr_reg + gbn_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == gbn_pkg::QPTR_W'(gbn_pkg::Q_DEPTH - 1)) ? '0
                        : rd_ptr_reg + gbn_pkg::QPTR_W'(1);
        end
        count_next = count_reg + gbn_pkg::QCNT_W'(do_push) - gbn_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/gbn_back.sv
// ----------------------------------------------------------------------------
// gbn_back
// Protocol state, retransmit ring and result sequencer with output register.
// ----------------------------------------------------------------------------
module gbn_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  gbn_pkg::cmd_t  q_cmd,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output gbn_pkg::res_t  res
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEND   = 2'd1;
    localparam logic [1:0] ST_STATUS = 2'd2;

    logic [gbn_pkg::REF_WIDTH-1:0] entry_ref_reg    [gbn_pkg::TABLE_SIZE];
    logic [gbn_pkg::LEN_W-1:0]     entry_length_reg [gbn_pkg::TABLE_SIZE];

    logic [1:0]                   state_reg,          state_next;
    logic [gbn_pkg::SEQ_W-1:0]    next_expected_reg,  next_expected_next;
    logic [gbn_pkg::SEQ_W-1:0]    next_send_reg,      next_send_next;
    logic [gbn_pkg::SEQ_W-1:0]    free_slot_reg,      free_slot_next;
    logic [gbn_pkg::SEQ_W-1:0]    oldest_unacked_reg, oldest_unacked_next;
    logic                         table_full_reg,     table_full_next;
    logic                         ack_pending_reg,    ack_pending_next;
    logic [gbn_pkg::CREDIT_W-1:0] credit_reg,         credit_next;
    logic [gbn_pkg::CREDIT_W-1:0] sent_reg,           sent_next;
    logic                         accepted_reg,       accepted_next;
    logic                         out_valid_reg,      out_valid_next;
    gbn_pkg::res_t                res_reg,            res_next;

    logic                         can_load;
    logic                         load;
    logic                         wr_en;
    gbn_pkg::res_t                res_new;
    logic [gbn_pkg::SEQ_W-1:0]    free_after;

    assign can_load   = !out_valid_reg || out_ready;
    assign free_after = gbn_pkg::ring_next(free_slot_reg);
    assign out_valid  = out_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        state_next          = state_reg;
        next_expected_next  = next_expected_reg;
        next_send_next      = next_send_reg;
        free_slot_next      = free_slot_reg;
        oldest_unacked_next = oldest_unacked_reg;
        table_full_next     = table_full_reg;
        ack_pending_next    = ack_pending_reg;
        credit_next         = credit_reg;
        sent_next           = sent_reg;
        accepted_next       = accepted_reg;
        q_pop               = 1'b0;
        load                = 1'b0;
        wr_en               = 1'b0;
        res_new             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && can_load)
                begin
                    q_pop         = 1'b1;
                    credit_next   = q_cmd.credit;
                    sent_next     = '0;
                    accepted_next = 1'b0;
                    state_next    = ST_SEND;
                    case (q_cmd.code)
                        gbn_pkg::CMD_DATA:
                        begin
                            load = 1'b1;
                            if (q_cmd.send_seq == next_expected_reg)
                            begin
                                next_expected_next = gbn_pkg::ring_next(next_expected_reg);
                                res_new.kind       = gbn_pkg::KIND_DELIVER;
                                res_new.buf_ref    = q_cmd.buf_ref;
                                res_new.length     = q_cmd.length;
                                ack_pending_next   = 1'b1;
                                if (oldest_unacked_reg != q_cmd.ack_seq)
                                begin
                                    oldest_unacked_next = q_cmd.ack_seq;
                                    table_full_next     = 1'b0;
                                end
                            end
                            else
                            begin
                                res_new.kind    = gbn_pkg::KIND_NACK;
                                res_new.ack_seq = next_expected_reg;
                            end
                        end
                        gbn_pkg::CMD_ACK:
                        begin
                            if (oldest_unacked_reg != q_cmd.ack_seq)
                            begin
                                oldest_unacked_next = q_cmd.ack_seq;
                                table_full_next     = 1'b0;
                            end
                        end
                        gbn_pkg::CMD_NACK:
                        begin
                            next_send_next = q_cmd.ack_seq;
                        end
                        gbn_pkg::CMD_QUEUE:
                        begin
                            if (!table_full_reg)
                            begin
                                accepted_next   = 1'b1;
                                wr_en           = 1'b1;
                                free_slot_next  = free_after;
                                table_full_next = (free_after == oldest_unacked_reg);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEND:
            begin
                if (can_load)
                begin
                    load = 1'b1;
                    if (next_send_reg != free_slot_reg && sent_reg < credit_reg)
                    begin
                        res_new.kind     = gbn_pkg::KIND_DATA;
                        res_new.send_seq = next_send_reg;
                        res_new.ack_seq  = next_expected_reg;
                        res_new.buf_ref  = entry_ref_reg[next_send_reg];
                        res_new.length   = entry_length_reg[next_send_reg];
                        ack_pending_next = 1'b0;
                        next_send_next   = gbn_pkg::ring_next(next_send_reg);
                        sent_next        = sent_reg + gbn_pkg::CREDIT_W'(1);
                    end
                    else if (ack_pending_reg && sent_reg < credit_reg)
                    begin
                        res_new.kind     = gbn_pkg::KIND_ACK;
                        res_new.ack_seq  = next_expected_reg;
                        ack_pending_next = 1'b0;
                        state_next       = ST_STATUS;
                    end
                    else
                    begin
                        res_new.kind     = gbn_pkg::KIND_STATUS;
                        res_new.accepted = accepted_reg;
                        res_new.last     = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
            end
            ST_STATUS:
            begin
                if (can_load)
                begin
                    load             = 1'b1;
                    res_new.kind     = gbn_pkg::KIND_STATUS;
                    res_new.accepted = accepted_reg;
                    res_new.last     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
            res_next       = res_new;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
            res_next       = res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (wr_en)
        begin
            entry_ref_reg[free_slot_reg]    <= q_cmd.buf_ref;
            entry_length_reg[free_slot_reg] <= q_cmd.length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            next_expected_reg  <= '0;
            next_send_reg      <= '0;
            free_slot_reg      <= '0;
            oldest_unacked_reg <= '0;
            table_full_reg     <= 1'b0;
            ack_pending_reg    <= 1'b0;
            credit_reg         <= '0;
            sent_reg           <= '0;
            accepted_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            next_expected_reg  <= next_expected_next;
            next_send_reg      <= next_send_next;
            free_slot_reg      <= free_slot_next;
            oldest_unacked_reg <= oldest_unacked_next;
            table_full_reg     <= table_full_next;
            ack_pending_reg    <= ack_pending_next;
            credit_reg         <= credit_next;
            sent_reg           <= sent_next;
            accepted_reg       <= accepted_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // frames sent never exceed the credit of the request
    a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg <= credit_reg)
        else $error("sent count above credit");

    // a full ring has its free pointer on the oldest unacked entry
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        table_full_reg |-> free_slot_reg == oldest_unacked_reg)
        else $error("full flag with pointers apart");

    // a new command is taken only between requests
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("command popped while sequencing");

    // a ring write never happens on a full ring
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !table_full_reg && q_cmd.code == gbn_pkg::CMD_QUEUE)
        else $error("ring written while full");

endmodule

// File: hdl/go_back_n_link_endpoint_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_link_endpoint_unit
// Go-back-N link endpoint: receive handling, retransmit ring, frame output.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    operation .. tx_credit
//  output    out_valid / out_ready  kind .. last
//
//  a request yields its results one after another from the back sequencer:
//  deliver or nack on data, data frames up to credit, a pending ack, status
//  a two-entry command queue lets up to two requests wait while results drain
//  reset clears pointers, flags, queue and output valid; ring contents stay
//  a stalled output holds its result and stops the sequencer
module go_back_n_link_endpoint_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [gbn_pkg::FTYPE_W-1:0]   frame_type,
    input  logic [gbn_pkg::SEQ_W-1:0]     frame_send_seq,
    input  logic [gbn_pkg::SEQ_W-1:0]     frame_ack_seq,
    input  logic [gbn_pkg::REF_WIDTH-1:0] payload_ref,
    input  logic [gbn_pkg::LEN_W-1:0]     payload_length,
    input  logic [gbn_pkg::CREDIT_W-1:0]  tx_credit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gbn_pkg::KIND_W-1:0]    kind,
    output logic [gbn_pkg::SEQ_W-1:0]     out_send_seq,
    output logic [gbn_pkg::SEQ_W-1:0]     out_ack_seq,
    output logic [gbn_pkg::REF_WIDTH-1:0] out_ref,
    output logic [gbn_pkg::LEN_W-1:0]     out_length,
    output logic                          accepted,
    output logic                          last
);

    gbn_pkg::cmd_t front_cmd;
    gbn_pkg::cmd_t head_cmd;
    gbn_pkg::res_t res;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;

    assign in_ready = !q_full;

    gbn_front u_front (
        .operation      (operation),
        .frame_type     (frame_type),
        .frame_send_seq (frame_send_seq),
        .frame_ack_seq  (frame_ack_seq),
        .payload_ref    (payload_ref),
        .payload_length (payload_length),
        .tx_credit      (tx_credit),
        .cmd            (front_cmd)
    );

    gbn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    gbn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign kind         = res.kind;
    assign out_send_seq = res.send_seq;
    assign out_ack_seq  = res.ack_seq;
    assign out_ref      = res.buf_ref;
    assign out_length   = res.length;
    assign accepted     = res.accepted;
    assign last         = res.last;

endmodule
